>>> hw/rtl/lzpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzpd_pkg;

    // history geometry
    localparam int HISTORY_DEPTH = 256;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W       = HIST_AW + 1;

    // match length limit
    localparam int MAX_MATCH = 64;
    localparam int LEN_W     = $clog2(MAX_MATCH + 1);

    // fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_CLAMP = 2'd1;
    localparam logic [1:0] FAULT_DIST  = 2'd2;

    // parser phase
    typedef enum logic [1:0] {
        PH_LITERAL = 2'd0,
        PH_MARKER  = 2'd1,
        PH_LENGTH  = 2'd2
    } phase_t;

    // sequencer state
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2
    } state_t;

    // input request
    typedef struct packed {
        logic [7:0] compressed_byte;
        logic       stream_start;
    } cmp_item_t;

    // output request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic [1:0] fault;
    } dec_item_t;

    // history port controls
    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } hist_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/lzpd_history.sv
`timescale 1ns / 1ps
`default_nettype none

module lzpd_history (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lzpd_pkg::hist_ctl_t ctl,
    output logic [7:0]             rdata
);

    logic [7:0]                     mem [lzpd_pkg::HISTORY_DEPTH];
    logic [lzpd_pkg::HISTORY_DEPTH-1:0] written_reg;
    logic [7:0]                     rdata_reg;
    logic                           rvalid_reg;

    // storage array, read data registered and held between reads
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[ctl.raddr];
        end
    end

    // per-entry written flags, never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.we)
            begin
                written_reg[ctl.waddr] <= 1'b1;
            end
            if (ctl.re)
            begin
                rvalid_reg <= written_reg[ctl.raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'd0;

endmodule

`default_nettype wire

>>> hw/rtl/lz_pair_decompressor.sv
`timescale 1ns / 1ps
`default_nettype none

// literal: stored, and its result is in the output register in the cycle after acceptance
// marker byte: no result
// match: a history read, then write-back and output, for each copied byte
// write-back waits for a free output register; the input is held until the run's last byte
// reset: parser expects a literal, counters clear, history reads as all zeros

module lz_pair_decompressor (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmp_valid,
    output logic                     cmp_ready,
    input  wire lzpd_pkg::cmp_item_t cmp_data,
    output logic                     dec_valid,
    input  wire logic                dec_ready,
    output lzpd_pkg::dec_item_t      dec_data
);

    lzpd_pkg::state_t                  state_reg, state_next;
    lzpd_pkg::phase_t                  phase_reg, phase_next;
    logic [7:0]                        dist_reg, dist_next;
    logic [lzpd_pkg::HIST_AW-1:0]      wp_reg, wp_next;
    logic [lzpd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [lzpd_pkg::LEN_W-1:0]        rem_reg, rem_next;
    logic [1:0]                        fault_reg, fault_next;
    logic                              out_valid_reg, out_valid_next;
    lzpd_pkg::dec_item_t               out_item_reg, out_item_next;

    lzpd_pkg::hist_ctl_t               hctl;
    logic [7:0]                        hist_rdata;

    logic                              out_free;
    logic                              accept;
    lzpd_pkg::phase_t                  phase_eff;
    logic [lzpd_pkg::COUNT_W-1:0]      count_eff;
    logic [lzpd_pkg::COUNT_W-1:0]      count_inc;
    logic [lzpd_pkg::HIST_AW-1:0]      src_addr;

    lzpd_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hctl),
        .rdata (hist_rdata)
    );

    assign out_free  = !out_valid_reg || dec_ready;
    assign cmp_ready = (state_reg == lzpd_pkg::ST_IDLE) && out_free;
    assign accept    = cmp_valid && cmp_ready;
    assign dec_valid = out_valid_reg;
    assign dec_data  = out_item_reg;

    // stream start restarts the parser and the produced count
    assign phase_eff = cmp_data.stream_start ? lzpd_pkg::PH_LITERAL : phase_reg;
    assign count_eff = cmp_data.stream_start ? '0 : count_reg;
    assign count_inc = (count_eff == lzpd_pkg::COUNT_W'(lzpd_pkg::HISTORY_DEPTH))
                     ? count_eff : count_eff + 1'b1;

    // copy source, distance always below the history depth
    assign src_addr = wp_reg - lzpd_pkg::HIST_AW'(dist_reg);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzpd_pkg::ST_IDLE;
            phase_reg     <= lzpd_pkg::PH_LITERAL;
            dist_reg      <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            fault_reg     <= lzpd_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            dist_reg      <= dist_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // parser and copy sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        dist_next      = dist_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !dec_ready;
        out_item_next  = out_item_reg;
        hctl.we        = 1'b0;
        hctl.waddr     = wp_reg;
        hctl.wdata     = cmp_data.compressed_byte;
        hctl.re        = 1'b0;
        hctl.raddr     = src_addr;

        case (state_reg)
            lzpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_eff;
                    case (phase_eff)
                        lzpd_pkg::PH_MARKER:
                        begin
                            if (cmp_data.compressed_byte == 8'd0)
                            begin
                                phase_next = lzpd_pkg::PH_LITERAL;
                            end
                            else
                            begin
                                dist_next  = cmp_data.compressed_byte;
                                phase_next = lzpd_pkg::PH_LENGTH;
                            end
                        end
                        lzpd_pkg::PH_LENGTH:
                        begin
                            phase_next = lzpd_pkg::PH_LITERAL;
                            if (cmp_data.compressed_byte > 8'(lzpd_pkg::MAX_MATCH))
                            begin
                                rem_next   = lzpd_pkg::LEN_W'(lzpd_pkg::MAX_MATCH);
                                fault_next = lzpd_pkg::FAULT_CLAMP;
                            end
                            else
                            begin
                                rem_next   = cmp_data.compressed_byte[lzpd_pkg::LEN_W-1:0];
                                fault_next = lzpd_pkg::FAULT_NONE;
                            end
                            if (lzpd_pkg::COUNT_W'(dist_reg) > count_eff)
                            begin
                                fault_next = lzpd_pkg::FAULT_DIST;
                            end
                            // zero length gives nothing
                            if (cmp_data.compressed_byte != 8'd0)
                            begin
                                state_next = lzpd_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            // literal: store and emit
                            hctl.we                 = 1'b1;
                            wp_next                 = wp_reg + 1'b1;
                            count_next              = count_inc;
                            out_valid_next          = 1'b1;
                            out_item_next.out_byte  = cmp_data.compressed_byte;
                            out_item_next.run_last  = 1'b1;
                            out_item_next.fault     = lzpd_pkg::FAULT_NONE;
                            phase_next              = lzpd_pkg::PH_MARKER;
                        end
                    endcase
                end
            end
            lzpd_pkg::ST_READ:
            begin
                hctl.re    = 1'b1;
                state_next = lzpd_pkg::ST_WRITE;
            end
            lzpd_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    // write back the copied byte and emit it
                    hctl.we                = 1'b1;
                    hctl.wdata             = hist_rdata;
                    wp_next                = wp_reg + 1'b1;
                    count_next             = (count_reg ==
                                              lzpd_pkg::COUNT_W'(lzpd_pkg::HISTORY_DEPTH))
                                           ? count_reg : count_reg + 1'b1;
                    rem_next               = rem_reg - 1'b1;
                    out_valid_next         = 1'b1;
                    out_item_next.out_byte = hist_rdata;
                    out_item_next.run_last = (rem_reg == lzpd_pkg::LEN_W'(1));
                    out_item_next.fault    = fault_reg;
                    state_next             = (rem_reg == lzpd_pkg::LEN_W'(1))
                                           ? lzpd_pkg::ST_IDLE : lzpd_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = lzpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> bench/tb_lz_pair_decompressor.sv
`timescale 1ns / 1ps

module tb_lz_pair_decompressor;

    // row length value that leaves the expected bytes to the predictor
    localparam int PREDICT       = -1;
    localparam int RANDOM_ITEMS  = 334;
    localparam int DRAIN_LIMIT   = 40000;
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 400;

    // one directed request with its hand-written outcome
    typedef struct {
        logic [7:0] cbyte;
        logic       start;
        int         n_typed;
        logic [7:0] t_byte;
        logic [1:0] t_fault;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cmp_valid;
    logic                cmp_ready;
    lzpd_pkg::cmp_item_t cmp_data;
    logic                dec_valid;
    logic                dec_ready;
    lzpd_pkg::dec_item_t dec_data;

    // predictor copy of the decoder state
    lzpd_pkg::phase_t             parse_phase;
    logic [7:0]                   match_dist;
    logic [7:0]                   hist_copy [lzpd_pkg::HISTORY_DEPTH];
    logic [lzpd_pkg::HIST_AW-1:0] hist_wp;
    logic [lzpd_pkg::COUNT_W-1:0] out_count;

    lzpd_pkg::dec_item_t step_bytes [$];
    lzpd_pkg::dec_item_t expected_bytes [$];
    stim_row_t           dir_rows [$];

    int                  mismatches;
    int                  results_seen;
    int                  items_sent;
    int                  burst_left;
    int                  hold_cnt;
    bit                  hold_done;
    int                  rx_tick;
    lzpd_pkg::dec_item_t want;

    lz_pair_decompressor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmp_valid (cmp_valid),
        .cmp_ready (cmp_ready),
        .cmp_data  (cmp_data),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_data  (dec_data)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // mismatch report
    task automatic report_mismatch(input string what, input int got, input int want_v);
        mismatches++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want_v);
    endtask

    // write one produced byte into the predictor history
    task automatic store_byte(input logic [7:0] b);
        hist_copy[hist_wp] = b;
        hist_wp = hist_wp + 1'b1;
        if (out_count < lzpd_pkg::HISTORY_DEPTH)
            out_count = out_count + 1'b1;
    endtask

    // decode one compressed byte into step_bytes
    task automatic lz_decode_step(input lzpd_pkg::cmp_item_t it);
        int unsigned                  run_len;
        logic [1:0]                   run_fault;
        logic [lzpd_pkg::HIST_AW-1:0] src;
        lzpd_pkg::dec_item_t          r;
        step_bytes.delete();
        if (it.stream_start)
        begin
            parse_phase = lzpd_pkg::PH_LITERAL;
            out_count = '0;
        end
        case (parse_phase)
            lzpd_pkg::PH_MARKER:
            begin
                if (it.compressed_byte == 8'd0)
                begin
                    parse_phase = lzpd_pkg::PH_LITERAL;
                end
                else
                begin
                    match_dist = it.compressed_byte;
                    parse_phase = lzpd_pkg::PH_LENGTH;
                end
            end
            lzpd_pkg::PH_LENGTH:
            begin
                parse_phase = lzpd_pkg::PH_LITERAL;
                run_len = 32'(it.compressed_byte);
                run_fault = lzpd_pkg::FAULT_NONE;
                if (run_len > lzpd_pkg::MAX_MATCH)
                begin
                    run_len = lzpd_pkg::MAX_MATCH;
                    run_fault = lzpd_pkg::FAULT_CLAMP;
                end
                // distance fault wins over the clamp
                if (match_dist > out_count)
                    run_fault = lzpd_pkg::FAULT_DIST;
                // forward copy, so overlapping runs repeat fresh bytes
                for (int k = 0; k < run_len; k++)
                begin
                    src = hist_wp - match_dist;
                    r.out_byte = hist_copy[src];
                    r.run_last = (k + 1 == run_len);
                    r.fault = run_fault;
                    store_byte(r.out_byte);
                    step_bytes.push_back(r);
                end
            end
            default:
            begin
                r.out_byte = it.compressed_byte;
                r.run_last = 1'b1;
                r.fault = lzpd_pkg::FAULT_NONE;
                store_byte(r.out_byte);
                step_bytes.push_back(r);
                parse_phase = lzpd_pkg::PH_MARKER;
            end
        endcase
    endtask

    // offer one request in bursts, wait until taken, then queue its output
    task automatic send_cmp(input lzpd_pkg::cmp_item_t it, input int n_typed,
                            input logic [7:0] t_byte, input logic [1:0] t_fault);
        int                  gap;
        lzpd_pkg::dec_item_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmp_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        cmp_valid <= 1'b1;
        cmp_data <= it;
        do @(posedge clk); while (cmp_ready !== 1'b1);
        lz_decode_step(it);
        if (n_typed == PREDICT)
        begin
            foreach (step_bytes[i])
                expected_bytes.push_back(step_bytes[i]);
        end
        else
        begin
            for (int k = 0; k < n_typed; k++)
            begin
                r.out_byte = t_byte;
                r.run_last = (k + 1 == n_typed);
                r.fault = t_fault;
                expected_bytes.push_back(r);
            end
        end
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && dec_valid && dec_ready)
        begin
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("result with nothing pending", int'(dec_data), 0);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (dec_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(dec_data.out_byte),
                                    int'(want.out_byte));
                if (dec_data.run_last !== want.run_last)
                    report_mismatch("run_last", int'(dec_data.run_last),
                                    int'(want.run_last));
                if (dec_data.fault !== want.fault)
                    report_mismatch("fault", int'(dec_data.fault), int'(want.fault));
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    initial
    begin
        dec_ready = 1'b0;
        hold_cnt = 0;
        hold_done = 1'b0;
        rx_tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                dec_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
                dec_ready <= 1'b0;
            end
            else
            begin
                case ((rx_tick / 97) % 3)
                    0:       dec_ready <= 1'b1;
                    1:       dec_ready <= ($urandom_range(0, 3) != 0);
                    default: dec_ready <= ((rx_tick % 7) < 4);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        lzpd_pkg::cmp_item_t it;
        logic [7:0]          dist_cap;
        int                  pick;
        int                  drain;
        int                  rand_base;

        rst_n = 1'b0;
        cmp_valid = 1'b0;
        cmp_data = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        burst_left = 0;

        // predictor after reset
        parse_phase = lzpd_pkg::PH_LITERAL;
        match_dist = '0;
        hist_wp = '0;
        out_count = '0;
        foreach (hist_copy[i])
            hist_copy[i] = 8'h00;

        // directed rows: byte, stream_start, result count, byte, fault
        // stream opens with a zero literal
        dir_rows.push_back('{8'h00, 1'b1, 1, 8'h00, lzpd_pkg::FAULT_NONE});
        // distance past the produced bytes, history still zero
        dir_rows.push_back('{8'h05, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h03, 1'b0, 3, 8'h00, lzpd_pkg::FAULT_DIST});
        // top literal, then zero marker
        dir_rows.push_back('{8'hFF, 1'b0, 1, 8'hFF, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h00, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        // overlapping copy of distance one, length clamped
        dir_rows.push_back('{8'hA5, 1'b0, 1, 8'hA5, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h01, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'hC8, 1'b0, lzpd_pkg::MAX_MATCH, 8'hA5, lzpd_pkg::FAULT_CLAMP});
        // longest distance and longest length, distance fault wins
        dir_rows.push_back('{8'h3C, 1'b0, 1, 8'h3C, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'hFF, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'hFF, 1'b0, lzpd_pkg::MAX_MATCH, 8'h00, lzpd_pkg::FAULT_DIST});
        // zero length gives nothing
        dir_rows.push_back('{8'h80, 1'b0, 1, 8'h80, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h02, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h00, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        // length exactly at the limit
        dir_rows.push_back('{8'h01, 1'b0, 1, 8'h01, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h02, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h40, 1'b0, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE});
        // new stream where a length was due
        dir_rows.push_back('{8'h7E, 1'b0, 1, 8'h7E, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h03, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h11, 1'b1, 1, 8'h11, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h01, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h01, 1'b0, 1, 8'h11, lzpd_pkg::FAULT_NONE});
        // new stream where a marker was due, then a far distance
        dir_rows.push_back('{8'h22, 1'b0, 1, 8'h22, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h00, 1'b1, 1, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h04, 1'b0, 0, 8'h00, lzpd_pkg::FAULT_NONE});
        dir_rows.push_back('{8'h02, 1'b0, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (dir_rows[i])
        begin
            it.compressed_byte = dir_rows[i].cbyte;
            it.stream_start = dir_rows[i].start;
            send_cmp(it, dir_rows[i].n_typed, dir_rows[i].t_byte, dir_rows[i].t_fault);
        end

        // random part: mostly literal, marker, length groups
        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS)
        begin
            // stray request that knocks the parser off its sequence
            if ($urandom_range(0, 14) == 0)
            begin
                it.compressed_byte = 8'($urandom_range(0, 255));
                it.stream_start = 1'($urandom_range(0, 1));
                send_cmp(it, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE);
            end

            // literal
            it.compressed_byte = 8'($urandom_range(0, 255));
            it.stream_start = ($urandom_range(0, 29) == 0);
            send_cmp(it, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE);

            // marker, mostly within the produced bytes
            dist_cap = (out_count > 255) ? 8'd255 : out_count[7:0];
            if ($urandom_range(0, 9) == 0)
                it.compressed_byte = 8'h00;
            else if (dist_cap != 0 && $urandom_range(0, 4) != 0)
                it.compressed_byte = 8'($urandom_range(1, dist_cap));
            else
                it.compressed_byte = 8'($urandom_range(1, 255));
            it.stream_start = ($urandom_range(0, 29) == 0);
            send_cmp(it, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE);

            // length, mostly short
            if (parse_phase == lzpd_pkg::PH_LENGTH)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    it.compressed_byte = 8'($urandom_range(0, 8));
                else if (pick < 9)
                    it.compressed_byte = 8'($urandom_range(9, lzpd_pkg::MAX_MATCH));
                else
                    it.compressed_byte = 8'($urandom_range(lzpd_pkg::MAX_MATCH + 1, 255));
                it.stream_start = ($urandom_range(0, 29) == 0);
                send_cmp(it, PREDICT, 8'h00, lzpd_pkg::FAULT_NONE);
            end
        end
        cmp_valid <= 1'b0;

        // drain outstanding results
        drain = 0;
        while (expected_bytes.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_bytes.size() != 0)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (mismatches == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
            $finish;
        end
    end

endmodule

>>> sim.f
hw/rtl/lzpd_pkg.sv
hw/rtl/lzpd_history.sv
hw/rtl/lz_pair_decompressor.sv
bench/tb_lz_pair_decompressor.sv
